// ===== src/dqd_pkg.sv =====
// Package for the double-ended queue with delete.
// Shared types, operation codes and port widths; no dependencies.
`default_nettype none

package dqd_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned FUNC_W      = 3;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned DATA_OUT_W  = 32;
  localparam int unsigned OCC_W       = 5;
  localparam int unsigned IN_TDATA_W  = ((FUNC_W + VALUE_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((DATA_OUT_W + 2 + OCC_W + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH    = 3'd0,
    FUNC_POP     = 3'd1,
    FUNC_UNSHIFT = 3'd2,
    FUNC_SHIFT   = 3'd3,
    FUNC_DELETE  = 3'd4
  } func_e;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic  en;
    func_e func;
  } cell_cmd_t;

endpackage : dqd_pkg

`default_nettype wire

// ===== src/dqd_cell.sv =====
// One storage cell of the queue row: holds a word, moves it to a neighbor.
// Depends on dqd_pkg for the command struct and operation codes.
`default_nettype none

module dqd_cell #(
  parameter int unsigned DataWidth = dqd_pkg::DATA_WIDTH_DEF
) (
  input  wire                  clk_i,
  input  wire dqd_pkg::cell_cmd_t cmd_i,
  input  wire  [DataWidth-1:0] value_i,
  input  wire                  valid_i,    // cell lies below the fill count
  input  wire                  at_tail_i,  // cell index equals the fill count
  input  wire  [DataWidth-1:0] left_i,     // word of the cell nearer the front
  input  wire  [DataWidth-1:0] right_i,    // word of the cell nearer the back
  input  wire                  hit_i,      // a match exists nearer the front
  output logic                 hit_o,
  output logic [DataWidth-1:0] data_o
);
  import dqd_pkg::*;

  logic [DataWidth-1:0] data_q, data_d;
  logic                 match;

  assign match  = valid_i && (data_q == value_i);
  assign hit_o  = hit_i | match;
  assign data_o = data_q;

  always_comb begin
    data_d = data_q;
    if (cmd_i.en) begin
      case (cmd_i.func)
        FUNC_PUSH:    if (at_tail_i) data_d = value_i;
        FUNC_UNSHIFT: data_d = left_i;
        FUNC_SHIFT:   data_d = right_i;
        // close the gap behind the first match
        FUNC_DELETE:  if (hit_o) data_d = right_i;
        default:      data_d = data_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule : dqd_cell

`default_nettype wire

// ===== src/deque_with_delete_core.sv =====
// Top level of the bounded double-ended queue with delete-by-value.
// Depends on dqd_pkg and dqd_cell (one cell per queue entry).
//
// Usage:
//   Slave channel s_axis_* carries one operation per beat: push back, pop back,
//   unshift front, shift front, or delete the first entry equal to the value.
//   Master channel m_axis_* returns exactly one result beat per operation:
//   removed word, hit flag, overflow flag and the entry count afterwards.
//   The result is registered and appears in the cycle after the operation is taken.
//   Throughput: one operation per cycle. The entries sit in a row of cells;
//   every cell moves its word to a neighbor in the same cycle, and the delete
//   match ripples through the row from front to back, which sets the cycle time.
//   The result sits in an output register; a new operation is taken while the
//   receiver takes the previous result, and s_axis_tready_o drops only while a
//   result is held and m_axis_tready_i is low.
//   Reset empties the queue (fill count zero) and drops any held result; the
//   cell contents are not cleared, since entries above the count are never read.
//   Pushes or unshifts on a full queue are refused with overflow set.
`default_nettype none

module deque_with_delete_core #(
  parameter int unsigned Depth     = dqd_pkg::DEPTH_DEF,
  parameter int unsigned DataWidth = dqd_pkg::DATA_WIDTH_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [2:0] func, [34:3] value, [39:35] zero
  input  wire  [dqd_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  wire                               m_axis_tready_i,
  // [31:0] data_out, [32] hit, [33] overflow, [38:34] occupancy, [39] zero
  output logic [dqd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);
  import dqd_pkg::*;

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned IdxW = $clog2(Depth);

  logic                  accept;
  func_e                 func;
  logic [VALUE_W-1:0]    value_in;
  logic [DataWidth+VALUE_W-1:0] value_ext;
  logic [DataWidth-1:0]  value_w;

  logic [CntW-1:0]       count_q, count_d;
  logic                  full, empty, is_insert;
  cell_cmd_t             cmd;

  logic [DataWidth-1:0]  cell_data [Depth];
  logic [DataWidth-1:0]  cell_left [Depth];
  logic [DataWidth-1:0]  cell_right[Depth];
  logic                  cell_hit_in [Depth];
  logic                  cell_hit_out[Depth];

  logic [CntW-1:0]       tail_cnt;
  logic [IdxW-1:0]       tail_idx;
  logic [DataWidth-1:0]  removed;
  logic [DataWidth+DATA_OUT_W-1:0] removed_ext;
  logic [CntW+OCC_W-1:0] occ_ext;

  logic                  res_hit, res_ovf;
  logic [DATA_OUT_W-1:0] res_data;

  logic                  out_valid_q;
  logic [DATA_OUT_W-1:0] out_data_q;
  logic                  out_hit_q, out_ovf_q;
  logic [OCC_W-1:0]      out_occ_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign func      = func_e'(s_axis_tdata_i[FUNC_W-1:0]);
  assign value_in  = s_axis_tdata_i[FUNC_W+VALUE_W-1:FUNC_W];
  assign value_ext = {{DataWidth{1'b0}}, value_in};
  assign value_w   = value_ext[DataWidth-1:0];

  assign full      = (count_q == CntW'(Depth));
  assign empty     = (count_q == '0);
  assign is_insert = (func == FUNC_PUSH) || (func == FUNC_UNSHIFT);

  assign cmd.en   = accept && !(is_insert && full);
  assign cmd.func = func;

  for (genvar k = 0; k < Depth; k++) begin : g_cell
    if (k == 0) begin : g_front
      assign cell_left[k]   = value_w;
      assign cell_hit_in[k] = 1'b0;
    end else begin : g_mid
      assign cell_left[k]   = cell_data[k-1];
      assign cell_hit_in[k] = cell_hit_out[k-1];
    end
    if (k == Depth - 1) begin : g_back
      assign cell_right[k] = cell_data[k];
    end else begin : g_inner
      assign cell_right[k] = cell_data[k+1];
    end

    dqd_cell #(
      .DataWidth (DataWidth)
    ) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .value_i   (value_w),
      .valid_i   (CntW'(k) < count_q),
      .at_tail_i (CntW'(k) == count_q),
      .left_i    (cell_left[k]),
      .right_i   (cell_right[k]),
      .hit_i     (cell_hit_in[k]),
      .hit_o     (cell_hit_out[k]),
      .data_o    (cell_data[k])
    );
  end

  assign tail_cnt    = count_q - 1'b1;
  assign tail_idx    = tail_cnt[IdxW-1:0];
  assign removed_ext = {{DATA_OUT_W{1'b0}}, removed};

  always_comb begin
    count_d = count_q;
    res_hit = 1'b0;
    res_ovf = 1'b0;
    removed = '0;
    case (func)
      FUNC_PUSH, FUNC_UNSHIFT: begin
        if (full) begin
          res_ovf = 1'b1;
        end else begin
          res_hit = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      FUNC_POP: begin
        if (!empty) begin
          res_hit = 1'b1;
          removed = cell_data[tail_idx];
          count_d = tail_cnt;
        end
      end
      FUNC_SHIFT: begin
        if (!empty) begin
          res_hit = 1'b1;
          removed = cell_data[0];
          count_d = tail_cnt;
        end
      end
      FUNC_DELETE: begin
        if (cell_hit_out[Depth-1]) begin
          res_hit = 1'b1;
          count_d = tail_cnt;
        end
      end
      default: count_d = count_q;
    endcase
    res_data = removed_ext[DATA_OUT_W-1:0];
  end

  assign occ_ext = {{OCC_W{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= res_data;
      out_hit_q  <= res_hit;
      out_ovf_q  <= res_ovf;
      out_occ_q  <= occ_ext[OCC_W-1:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W - DATA_OUT_W - 2 - OCC_W){1'b0}},
                            out_occ_q, out_ovf_q, out_hit_q, out_data_q};

  // Fill count never passes the row length.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("fill count above depth");

  // A result never reports both effect and refusal.
  a_hit_ovf_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_hit_q && out_ovf_q))
    else $error("hit and overflow both set");

  // An insert into a non-full queue grows the count by one.
  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_insert && !full) |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the count");

  // An insert into a full queue is flagged and leaves the count alone.
  a_full_refuse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_insert && full) |=> (out_ovf_q && $stable(count_q)))
    else $error("insert on full queue not refused");

endmodule : deque_with_delete_core

`default_nettype wire

// ===== dv/deque_with_delete_core_tb.sv =====
// Self-checking testbench for deque_with_delete_core: an in-bench mirror of the queue
// predicts every result beat, and random bursts and receiver stalls stress the handshake.
// Depends on dqd_pkg and the RTL under src/.
`timescale 1ns / 100ps

module deque_with_delete_core_tb;
  import dqd_pkg::*;

  localparam int unsigned QDEPTH    = DEPTH_DEF;
  localparam int unsigned NUM_RAND  = 500;
  localparam int unsigned MAX_CYCLE = 200000;
  // func codes the block treats as no-ops
  localparam logic [FUNC_W-1:0] FUNC_RSVD_LO  = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_RSVD_MID = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_RSVD_HI  = 3'd7;

  typedef struct packed {
    logic [OCC_W-1:0]      occupancy;
    logic                  overflow;
    logic                  hit;
    logic [DATA_OUT_W-1:0] data_out;
  } deque_result_t;

  // Mirror of the queue contents, front at index 0.
  class deque_mirror;
    logic [VALUE_W-1:0] words[$];
    deque_result_t      expected_results[$];
    int                 errors = 0;

    function void apply_op(logic [FUNC_W-1:0] f, logic [VALUE_W-1:0] v);
      deque_result_t r;
      r = '0;
      case (f)
        FUNC_PUSH, FUNC_UNSHIFT: begin
          if (words.size() >= QDEPTH) begin
            r.overflow = 1'b1;
          end else begin
            if (f == FUNC_PUSH) words.push_back(v);
            else words.push_front(v);
            r.hit = 1'b1;
          end
        end
        FUNC_POP, FUNC_SHIFT: begin
          if (words.size() > 0) begin
            r.data_out = (f == FUNC_POP) ? words.pop_back() : words.pop_front();
            r.hit = 1'b1;
          end
        end
        FUNC_DELETE: begin
          for (int i = 0; i < words.size(); i++) begin
            if (words[i] == v) begin
              words.delete(i);
              r.hit = 1'b1;
              break;
            end
          end
        end
        default: ;
      endcase
      r.occupancy = OCC_W'(words.size());
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] td);
      deque_result_t got, exp;
      got = td[$bits(deque_result_t)-1:0];
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: %h", td);
        errors++;
        return;
      end
      exp = expected_results.pop_front();
      if (got.data_out !== exp.data_out) begin
        $error("data_out: expected %h, got %h", exp.data_out, got.data_out);
        errors++;
      end
      if (got.hit !== exp.hit) begin
        $error("hit: expected %b, got %b", exp.hit, got.hit);
        errors++;
      end
      if (got.overflow !== exp.overflow) begin
        $error("overflow: expected %b, got %b", exp.overflow, got.overflow);
        errors++;
      end
      if (got.occupancy !== exp.occupancy) begin
        $error("occupancy: expected %0d, got %0d", exp.occupancy, got.occupancy);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  // [2:0] func, [34:3] value, [39:35] zero
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  // [31:0] data_out, [32] hit, [33] overflow, [38:34] occupancy, [39] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  deque_mirror mirror;
  int unsigned cycle_cnt = 0;
  logic [VALUE_W-1:0] value_pool[6] = '{32'h0, 32'h1, 32'h7, 32'hFFFF_FFFF,
                                        32'h8000_0000, 32'hA5A5_5A5A};

  deque_with_delete_core dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) mirror.check_result(m_axis_tdata_o);
  end

  // Receiver back-pressure; bits [7:6] of the cycle counter pick the pattern
  always @(posedge clk_i) begin
    case (cycle_cnt[7:6])
      2'd0: m_axis_tready_i <= 1'b1;
      2'd1: m_axis_tready_i <= 1'($urandom_range(0, 1));
      2'd2: m_axis_tready_i <= (cycle_cnt[1:0] == 2'd0);
      default: m_axis_tready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Holds the beat until it is taken; returns at the accepting edge.
  task automatic send_op(input logic [FUNC_W-1:0] f, input logic [VALUE_W-1:0] v);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(IN_TDATA_W - FUNC_W - VALUE_W){1'b0}}, v, f};
    forever begin
      @(posedge clk_i);
      if (s_axis_tready_o) break;
    end
    mirror.apply_op(f, v);
  endtask

  task automatic idle_for(input int unsigned n);
    if (n > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (mirror.expected_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return value_pool[$urandom_range(0, 5)];
    // bias values toward words that are actually held
    if (r < 75 && mirror.words.size() > 0)
      return mirror.words[$urandom_range(0, mirror.words.size() - 1)];
    return $urandom();
  endfunction

  initial begin
    int unsigned burst_left;
    int unsigned r;
    int unsigned ins_pct;
    int unsigned rem_pct;
    logic [FUNC_W-1:0] f;

    mirror = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue
    send_op(FUNC_POP, 32'hFFFF_FFFF);
    send_op(FUNC_SHIFT, 32'h1234_5678);
    send_op(FUNC_DELETE, 32'h0);
    send_op(FUNC_PUSH, 32'h0);
    send_op(FUNC_PUSH, 32'hFFFF_FFFF);
    send_op(FUNC_UNSHIFT, 32'h5A5A_A5A5);
    send_op(FUNC_DELETE, 32'h0000_0003);    // no match
    send_op(FUNC_RSVD_LO, 32'hFFFF_FFFF);
    send_op(FUNC_RSVD_MID, 32'h0);
    send_op(FUNC_RSVD_HI, 32'hDEAD_BEEF);
    // fill up with duplicates so delete must take the frontmost
    for (int i = 0; i < 13; i++) send_op(FUNC_PUSH, (i % 2) ? 32'h7 : 32'h8000_0000 + i);
    send_op(FUNC_PUSH, 32'h1111_1111);      // full
    send_op(FUNC_UNSHIFT, 32'h2222_2222);   // full
    send_op(FUNC_DELETE, 32'h7);
    send_op(FUNC_DELETE, 32'hFFFF_FFFF);
    send_op(FUNC_POP, 32'h0);
    send_op(FUNC_SHIFT, 32'h0);
    drain_results();

    burst_left = 0;
    for (int n = 0; n < NUM_RAND; n++) begin
      if (n == NUM_RAND / 2) drain_results();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        r = $urandom_range(0, 3);
        if (r == 0) idle_for($urandom_range(5, 20));
        else if (r == 1) idle_for($urandom_range(1, 4));
      end
      burst_left--;

      // alternate filling, draining and balanced phases
      case ((n / 50) % 3)
        0: begin ins_pct = 55; rem_pct = 20; end
        1: begin ins_pct = 20; rem_pct = 55; end
        default: begin ins_pct = 35; rem_pct = 35; end
      endcase
      r = $urandom_range(0, 99);
      if (r < ins_pct) f = $urandom_range(0, 1) ? FUNC_PUSH : FUNC_UNSHIFT;
      else if (r < ins_pct + rem_pct) f = $urandom_range(0, 1) ? FUNC_POP : FUNC_SHIFT;
      else if (r < 97) f = FUNC_DELETE;
      else f = FUNC_W'($urandom_range(FUNC_RSVD_LO, FUNC_RSVD_HI));
      send_op(f, pick_value());
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (mirror.errors == 0 && mirror.expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
